// File: src/pairwise_cutoff_neighbor_mask_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the neighbor mask block
// Shared concurrent assertion helpers, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_CUTOFF_NEIGHBOR_MASK_TOP_DEFINES_SVH
`define PAIRWISE_CUTOFF_NEIGHBOR_MASK_TOP_DEFINES_SVH

// Checked only outside reset.
`define PCNM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising edge of clk_i, during reset too.
`define PCNM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: src/pcnm_pkg.sv
// ----------------------------------------------------------------------------
// Neighbor mask package
// Sizes and constants of the distance cutoff neighbor search.
// ----------------------------------------------------------------------------
package pcnm_pkg;

  localparam int MAX_ATOMS   = 64;
  localparam int COORD_BITS  = 24;
  localparam int CUTOFF_BITS = 50;
  localparam int INDEX_BITS  = 6;
  localparam int MASK_BITS   = 64;

  localparam int IDX_BITS = $clog2(MAX_ATOMS);
  localparam int CNT_BITS = $clog2(MAX_ATOMS + 1);
  localparam int SQ_BITS  = 2 * COORD_BITS;
  localparam int SUM_BITS = SQ_BITS + 2;
  localparam int CMP_BITS = (SUM_BITS > CUTOFF_BITS) ? SUM_BITS : CUTOFF_BITS;

  localparam logic [CUTOFF_BITS-1:0] CUTOFF_RESET = CUTOFF_BITS'(2683044);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [SQ_BITS-1:0]    square_t;

endpackage

// File: src/pairwise_cutoff_neighbor_mask_top.sv
// ----------------------------------------------------------------------------
// Pairwise cutoff neighbor mask
// Stores atoms of a set and flags every earlier atom within a squared cutoff.
// ----------------------------------------------------------------------------
// A dropped atom goes straight to the result, and the first atom of a set has no
// earlier atom to compare; a new atom is taken only while the block is idle.
// A single distance unit evaluates one stored atom per cycle, fed by the single
// read port of the coordinate store.
// Reset clears the atom count and loads the default cutoff; the store is not
// cleared, so the block is ready right after reset.
module pairwise_cutoff_neighbor_mask_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pcnm_pkg::CUTOFF_BITS-1:0]  cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              new_set_i,
  input  logic signed [pcnm_pkg::COORD_BITS-1:0] x_coord_i,
  input  logic signed [pcnm_pkg::COORD_BITS-1:0] y_coord_i,
  input  logic signed [pcnm_pkg::COORD_BITS-1:0] z_coord_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pcnm_pkg::INDEX_BITS-1:0]   atom_index_o,
  output logic [pcnm_pkg::MASK_BITS-1:0]    neighbor_mask_o,
  output logic                              overflow_o
);
  import pcnm_pkg::*;

  `include "pairwise_cutoff_neighbor_mask_top_defines.svh"

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CUTOFF_BITS-1:0] cutoff_q;
  logic [CNT_BITS-1:0]    total_q;
  logic [CNT_BITS-1:0]    limit_q;
  logic [CNT_BITS-1:0]    issue_q;
  logic [CNT_BITS-1:0]    eff_total;
  coord_t                 x_q, y_q, z_q;
  logic [INDEX_BITS-1:0]  cur_idx_q;
  logic                   ovf_q;
  logic [MASK_BITS-1:0]   mask_acc_q;

  logic [3*COORD_BITS-1:0] store_mem [MAX_ATOMS];
  logic [3*COORD_BITS-1:0] rdata_q;

  logic                v1_q, v2_q, v3_q;
  logic [IDX_BITS-1:0] idx1_q, idx2_q, idx3_q;
  coord_t              mag_x_q, mag_y_q, mag_z_q;
  square_t             sq_x_q, sq_y_q, sq_z_q;

  logic                  out_valid_q;
  logic [INDEX_BITS-1:0] out_idx_q;
  logic [MASK_BITS-1:0]  out_mask_q;
  logic                  out_ovf_q;

  logic accept, full, issuing, drained, load_out, in_cutoff;
  logic [SUM_BITS-1:0] dist_sum;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign eff_total  = new_set_i ? '0 : total_q;
  assign full       = (eff_total >= CNT_BITS'(MAX_ATOMS));
  assign issuing    = (state_q == ST_RUN) && (issue_q != limit_q);
  assign drained    = !issuing && !v1_q && !v2_q && !v3_q;
  assign load_out   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // Absolute difference of two sign-extended coordinates; it always fits.
  function automatic coord_t abs_diff(input coord_t a, input coord_t b);
    logic signed [COORD_BITS:0] d;
    d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    abs_diff = d[COORD_BITS] ? COORD_BITS'(-d) : d[COORD_BITS-1:0];
  endfunction

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = full ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (drained) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cutoff_q <= CUTOFF_RESET;
      total_q  <= '0;
      limit_q  <= '0;
      issue_q  <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cutoff_q <= cfg_wdata_i;
      end
      if (accept) begin
        issue_q <= '0;
        if (full) begin
          total_q <= eff_total;
          limit_q <= '0;
        end else begin
          total_q <= eff_total + CNT_BITS'(1);
          limit_q <= eff_total;
        end
      end else if (issuing) begin
        issue_q <= issue_q + CNT_BITS'(1);
      end
      v1_q <= issuing;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Coordinate store: the new atom goes in at its own index, which the
  // comparisons of this transaction never read.
  always_ff @(posedge clk_i) begin
    if (accept && !full) begin
      store_mem[eff_total[IDX_BITS-1:0]] <= {x_coord_i, y_coord_i, z_coord_i};
    end
    rdata_q <= store_mem[issue_q[IDX_BITS-1:0]];
  end

  // Distance unit: differences, then squares, then sum and compare.
  assign dist_sum  = SUM_BITS'(sq_x_q) + SUM_BITS'(sq_y_q) + SUM_BITS'(sq_z_q);
  assign in_cutoff = (CMP_BITS'(dist_sum) < CMP_BITS'(cutoff_q));

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q        <= x_coord_i;
      y_q        <= y_coord_i;
      z_q        <= z_coord_i;
      cur_idx_q  <= full ? '0 : INDEX_BITS'(eff_total);
      ovf_q      <= full;
      mask_acc_q <= '0;
    end else if (v3_q && in_cutoff) begin
      mask_acc_q[idx3_q] <= 1'b1;
    end
    idx1_q  <= issue_q[IDX_BITS-1:0];
    idx2_q  <= idx1_q;
    idx3_q  <= idx2_q;
    mag_x_q <= abs_diff(x_q, rdata_q[3*COORD_BITS-1:2*COORD_BITS]);
    mag_y_q <= abs_diff(y_q, rdata_q[2*COORD_BITS-1:COORD_BITS]);
    mag_z_q <= abs_diff(z_q, rdata_q[COORD_BITS-1:0]);
    sq_x_q  <= mag_x_q * mag_x_q;
    sq_y_q  <= mag_y_q * mag_y_q;
    sq_z_q  <= mag_z_q * mag_z_q;
    if (load_out) begin
      out_idx_q  <= cur_idx_q;
      out_mask_q <= mask_acc_q;
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign atom_index_o    = out_idx_q;
  assign neighbor_mask_o = out_mask_q;
  assign overflow_o      = out_ovf_q;

  `PCNM_ASSERT(a_ovf_clean, out_valid_o && overflow_o |-> neighbor_mask_o == '0 && atom_index_o == '0, "dropped atom carries a nonzero index or mask")
  `PCNM_ASSERT(a_mask_earlier, out_valid_o && !overflow_o |-> (neighbor_mask_o >> atom_index_o) == '0, "mask flags an atom that is not earlier")
  `PCNM_ASSERT(a_pipe_in_run, v1_q |-> state_q == ST_RUN, "distance read outside of a search")
  `PCNM_ASSERT(a_issue_bound, state_q == ST_RUN |-> issue_q <= limit_q && limit_q < total_q, "search reads beyond the stored atoms")
  `PCNM_ASSERT_ALWAYS(a_total_bound, total_q <= CNT_BITS'(MAX_ATOMS), "atom count beyond store depth")

endmodule
